// ===== rtl/core/binned_batch_dispatcher_macros.svh =====
// assertion macros for the bound checker file
`ifndef BINNED_BATCH_DISPATCHER_MACROS_SVH
`define BINNED_BATCH_DISPATCHER_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define BBD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define BBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bbd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bbd_pkg;

    // fixed field widths
    localparam int BIN_W   = 6;
    localparam int CNT_W   = 8;
    localparam int EVT_W   = 16;
    localparam int ITEM_W  = 20;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // request codes
    localparam logic [1:0] REQ_ADD        = 2'd0;
    localparam logic [1:0] REQ_FLUSH_PRI  = 2'd1;
    localparam logic [1:0] REQ_FLUSH_NORM = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_HELD     = 2'd0;
    localparam logic [1:0] STAT_DISPATCH = 2'd1;
    localparam logic [1:0] STAT_REFUSED  = 2'd2;
    localparam logic [1:0] STAT_EMPTY    = 2'd3;

    // register indexes
    localparam logic [1:0] REG_PRI_EN    = 2'd0;
    localparam logic [1:0] REG_PRI_FIRST = 2'd1;
    localparam logic [1:0] REG_PRI_LAST  = 2'd2;
    localparam logic [1:0] REG_BSIZE     = 2'd3;

    localparam logic [CNT_W-1:0] BSIZE_RESET = 8'd16;
    localparam logic [CNT_W:0]   CNT_CAP     = 9'd255;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCAN,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/bbd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/binned_batch_dispatcher.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                 payload
// request   in         i_in_valid / o_in_ready   i_req_type i_item_id i_bin_index
//                                                i_event_number i_item_alive
// result    out        o_out_valid / i_out_ready o_status o_out_bin o_out_priority
//                                                o_out_count o_last
// config    in         psel penable pwrite       paddr pwdata prdata pready
//
// an add reads its count from the count ram, then updates it and registers the result
// a flush reads every bin of its class from the count ram in bin order, and output stalls hold it
// a refused add goes straight to its closing result; an unknown request gives no result
// synchronous reset clears all counts at once through per-entry valid flops
// a valid result word holds while i_out_ready is low; the sequencer waits on it

module binned_batch_dispatcher
    import bbd_pkg::*;
#(
    parameter int NUM_BINS = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // request channel
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [1:0]        i_req_type,
    input  wire logic [ITEM_W-1:0] i_item_id,
    input  wire logic [BIN_W-1:0]  i_bin_index,
    input  wire logic [EVT_W-1:0]  i_event_number,
    input  wire logic              i_item_alive,
    // result channel
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [1:0]             o_status,
    output logic [BIN_W-1:0]       o_out_bin,
    output logic                   o_out_priority,
    output logic [CNT_W-1:0]       o_out_count,
    output logic                   o_last,
    // register port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    localparam int BW    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int AW    = BW + 1;
    localparam int DEPTH = 2 ** AW;
    localparam logic [BW-1:0]  LAST_BIN = BW'(NUM_BINS - 1);
    localparam logic [BIN_W:0] BIN_LIM  = (BIN_W + 1)'(NUM_BINS);

    // config registers
    logic              r_pri_en;
    logic [EVT_W-1:0]  r_pri_first;
    logic [EVT_W-1:0]  r_pri_last;
    logic [CNT_W-1:0]  r_bsize;

    // sequencer and datapath registers
    t_state            r_state, n_state;
    logic              r_cls_n, n_cls_n;
    logic [BW-1:0]     r_bin, n_bin;
    logic              r_pend_vld, n_pend_vld;
    logic [1:0]        r_pend_stat, n_pend_stat;
    logic [BIN_W-1:0]  r_pend_bin, n_pend_bin;
    logic              r_pend_pri, n_pend_pri;
    logic [CNT_W-1:0]  r_pend_cnt, n_pend_cnt;
    logic [DEPTH-1:0]  r_vld;

    // ram and emit controls
    logic [AW-1:0]     ram_raddr;
    logic [CNT_W-1:0]  ram_rdata;
    logic              ram_we;
    logic [AW-1:0]     cur_addr;
    logic              vld_set, vld_clr;
    logic              emit;
    logic [1:0]        e_stat;
    logic [BIN_W-1:0]  e_bin;
    logic              e_pri;
    logic [CNT_W-1:0]  e_cnt;
    logic              e_last;

    logic              accept, out_free, acc_pri, acc_refuse, cur_nz, advance, disp;
    logic [CNT_W:0]    cnt_inc;

    assign pready     = 1'b1;
    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !o_out_valid || i_out_ready;
    assign cur_addr   = {r_cls_n, r_bin};

    // priority window and refusal checks on the incoming word
    assign acc_pri    = r_pri_en && (i_event_number >= r_pri_first)
                        && (i_event_number <= r_pri_last);
    assign acc_refuse = !i_item_alive || ({1'b0, i_bin_index} >= BIN_LIM);

    // count update for an add; a valid entry always holds a nonzero count
    assign cur_nz  = r_vld[cur_addr];
    assign cnt_inc = {1'b0, (cur_nz ? ram_rdata : '0)} + 1'b1;
    assign disp    = (cnt_inc >= {1'b0, r_bsize}) || (cnt_inc >= CNT_CAP);

    // scan moves on unless a second batch is found while the result register is full
    assign advance = !(cur_nz && r_pend_vld && !out_free);

    // register port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pri_en    <= 1'b0;
            r_pri_first <= '0;
            r_pri_last  <= '0;
            r_bsize     <= BSIZE_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_PRI_EN:    r_pri_en    <= pwdata[0];
                REG_PRI_FIRST: r_pri_first <= pwdata[EVT_W-1:0];
                REG_PRI_LAST:  r_pri_last  <= pwdata[EVT_W-1:0];
                REG_BSIZE:     r_bsize     <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_PRI_EN:    prdata = {{(DATA_W-1){1'b0}}, r_pri_en};
            REG_PRI_FIRST: prdata = {{(DATA_W-EVT_W){1'b0}}, r_pri_first};
            REG_PRI_LAST:  prdata = {{(DATA_W-EVT_W){1'b0}}, r_pri_last};
            REG_BSIZE:     prdata = {{(DATA_W-CNT_W){1'b0}}, r_bsize};
            default:       prdata = '0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_req_type)
                        REQ_ADD:        n_state = acc_refuse ? ST_FIN : ST_ADD;
                        REQ_FLUSH_PRI:  n_state = ST_SCAN;
                        REQ_FLUSH_NORM: n_state = ST_SCAN;
                        default:        n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ADD: begin
                if (out_free) n_state = ST_IDLE;
            end
            ST_SCAN: begin
                if (advance && (r_bin == LAST_BIN)) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and result controls
    always_comb begin
        n_cls_n     = r_cls_n;
        n_bin       = r_bin;
        n_pend_vld  = r_pend_vld;
        n_pend_stat = r_pend_stat;
        n_pend_bin  = r_pend_bin;
        n_pend_pri  = r_pend_pri;
        n_pend_cnt  = r_pend_cnt;
        ram_raddr   = cur_addr;
        ram_we      = 1'b0;
        vld_set     = 1'b0;
        vld_clr     = 1'b0;
        emit        = 1'b0;
        e_stat      = STAT_HELD;
        e_bin       = '0;
        e_pri       = 1'b0;
        e_cnt       = '0;
        e_last      = 1'b1;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_req_type)
                        REQ_ADD: begin
                            n_cls_n     = !acc_pri;
                            n_bin       = i_bin_index[BW-1:0];
                            n_pend_vld  = acc_refuse;
                            n_pend_stat = STAT_REFUSED;
                            n_pend_bin  = i_bin_index;
                            n_pend_pri  = 1'b0;
                            n_pend_cnt  = '0;
                            ram_raddr   = {!acc_pri, i_bin_index[BW-1:0]};
                        end
                        REQ_FLUSH_PRI, REQ_FLUSH_NORM: begin
                            n_cls_n    = (i_req_type == REQ_FLUSH_NORM);
                            n_bin      = '0;
                            n_pend_vld = 1'b0;
                            ram_raddr  = {(i_req_type == REQ_FLUSH_NORM), {BW{1'b0}}};
                        end
                        default: ;
                    endcase
                end
            end
            ST_ADD: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_stat  = disp ? STAT_DISPATCH : STAT_HELD;
                    e_bin   = BIN_W'(r_bin);
                    e_pri   = !r_cls_n;
                    e_cnt   = cnt_inc[CNT_W-1:0];
                    vld_clr = disp;
                    vld_set = !disp;
                    ram_we  = !disp;
                end
            end
            ST_SCAN: begin
                if (advance) begin
                    ram_raddr = {r_cls_n, r_bin + 1'b1};
                    n_bin     = r_bin + 1'b1;
                    if (cur_nz) begin
                        // hand on the batch found before and hold this one
                        emit        = r_pend_vld;
                        e_stat      = r_pend_stat;
                        e_bin       = r_pend_bin;
                        e_pri       = r_pend_pri;
                        e_cnt       = r_pend_cnt;
                        e_last      = 1'b0;
                        vld_clr     = 1'b1;
                        n_pend_vld  = 1'b1;
                        n_pend_stat = STAT_DISPATCH;
                        n_pend_bin  = BIN_W'(r_bin);
                        n_pend_pri  = !r_cls_n;
                        n_pend_cnt  = ram_rdata;
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    emit       = 1'b1;
                    n_pend_vld = 1'b0;
                    if (r_pend_vld) begin
                        e_stat = r_pend_stat;
                        e_bin  = r_pend_bin;
                        e_pri  = r_pend_pri;
                        e_cnt  = r_pend_cnt;
                    end else begin
                        e_stat = STAT_EMPTY;
                        e_pri  = !r_cls_n;
                    end
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_pend_vld <= 1'b0;
            r_vld      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pend_vld <= n_pend_vld;
            if (vld_set) r_vld[cur_addr] <= 1'b1;
            if (vld_clr) r_vld[cur_addr] <= 1'b0;
            if (emit) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cls_n     <= n_cls_n;
        r_bin       <= n_bin;
        r_pend_stat <= n_pend_stat;
        r_pend_bin  <= n_pend_bin;
        r_pend_pri  <= n_pend_pri;
        r_pend_cnt  <= n_pend_cnt;
        if (emit) begin
            o_status       <= e_stat;
            o_out_bin      <= e_bin;
            o_out_priority <= e_pri;
            o_out_count    <= e_cnt;
            o_last         <= e_last;
        end
    end

    // batch counts, priority class in the lower half
    bbd_ram #(
        .WIDTH (CNT_W),
        .DEPTH (DEPTH)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (cur_addr),
        .i_wdata (cnt_inc[CNT_W-1:0]),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

`default_nettype wire

// ===== rtl/core/bbd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "binned_batch_dispatcher_macros.svh"

module bbd_checker
    import bbd_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_ready,
    input wire logic [1:0]        i_req_type,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire logic [1:0]        o_status,
    input wire logic [BIN_W-1:0]  o_out_bin,
    input wire logic              o_out_priority,
    input wire logic [CNT_W-1:0]  o_out_count,
    input wire logic              o_last
);

    // a stalled result word holds
    `BBD_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_status) && $stable(o_out_bin) && $stable(o_out_count) && $stable(o_last), "result word changed under stall")

    // an add keeps the block busy while it is updated or refused
    `BBD_ASSERT_NEXT(a_add_busy, i_in_valid && o_in_ready && i_req_type == REQ_ADD, !o_in_ready, "ready right after an add")

    // empty flush notice is a single closing word with no batch
    `BBD_ASSERT_NOW(a_empty_shape, o_out_valid && o_status == STAT_EMPTY, o_last && o_out_count == '0 && o_out_bin == '0, "bad empty notice")

    // refused item carries no count and no class
    `BBD_ASSERT_NOW(a_refuse_shape, o_out_valid && o_status == STAT_REFUSED, o_last && o_out_count == '0 && !o_out_priority, "bad refused word")

    // a held item always closes its add with a nonzero count
    `BBD_ASSERT_NOW(a_held_shape, o_out_valid && o_status == STAT_HELD, o_last && o_out_count != '0, "bad held word")

endmodule

bind binned_batch_dispatcher bbd_checker u_bbd_checker (.*);

`default_nettype wire

// ===== verif/binned_batch_dispatcher_checker.sv =====
`timescale 1ns / 1ps

module binned_batch_dispatcher_checker
    import bbd_pkg::*;
#(
    parameter int NUM_BINS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [1:0]        i_req_type,
    input  logic [BIN_W-1:0]  i_bin_index,
    input  logic [EVT_W-1:0]  i_event_number,
    input  logic              i_item_alive,
    // result channel
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [1:0]        i_status,
    input  logic [BIN_W-1:0]  i_out_bin,
    input  logic              i_out_priority,
    input  logic [CNT_W-1:0]  i_out_count,
    input  logic              i_last,
    // register port
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0] i_pwdata,
    output int                o_mismatch_count,
    output int                o_pending
);

    typedef struct packed {
        logic [1:0]       status;
        logic [BIN_W-1:0] bin;
        logic             pri;
        logic [CNT_W-1:0] count;
        logic             last;
    } t_result;

    // expected results, oldest first
    t_result          expected_q[$];

    // shadow batch counts: priority class at 0..NUM_BINS-1, normal class above
    logic [CNT_W-1:0] batch_tally [2*NUM_BINS];

    // shadow registers
    logic             pri_en;
    logic [EVT_W-1:0] win_first;
    logic [EVT_W-1:0] win_last;
    logic [CNT_W-1:0] batch_limit;

    int               mismatches;

    function automatic t_result make_result(input logic [1:0] status,
                                            input logic [BIN_W-1:0] bin,
                                            input logic pri,
                                            input logic [CNT_W-1:0] count,
                                            input logic last);
        t_result r;
        r.status = status;
        r.bin    = bin;
        r.pri    = pri;
        r.count  = count;
        r.last   = last;
        return r;
    endfunction

    // one add word: refuse, hold or dispatch its batch
    task automatic predict_add(input logic [BIN_W-1:0] bin, input logic [EVT_W-1:0] ev,
                               input logic alive);
        logic           pri;
        int             slot;
        logic [CNT_W:0] next_count;
        if (!alive || int'(bin) >= NUM_BINS) begin
            expected_q.push_back(make_result(STAT_REFUSED, bin, 1'b0, '0, 1'b1));
        end else begin
            pri        = pri_en && (ev >= win_first) && (ev <= win_last);
            slot       = pri ? int'(bin) : NUM_BINS + int'(bin);
            next_count = {1'b0, batch_tally[slot]} + 1'b1;
            if (next_count >= {1'b0, batch_limit} || next_count >= CNT_CAP) begin
                batch_tally[slot] = '0;
                expected_q.push_back(make_result(STAT_DISPATCH, bin, pri,
                                                 next_count[CNT_W-1:0], 1'b1));
            end else begin
                batch_tally[slot] = next_count[CNT_W-1:0];
                expected_q.push_back(make_result(STAT_HELD, bin, pri,
                                                 next_count[CNT_W-1:0], 1'b1));
            end
        end
    endtask

    // flush of one class: every non-empty batch in bin order, or one empty notice
    task automatic predict_flush(input logic pri);
        int      base;
        bit      found;
        t_result held;
        base  = pri ? 0 : NUM_BINS;
        found = 1'b0;
        held  = '0;
        for (int b = 0; b < NUM_BINS; b++) begin
            if (batch_tally[base + b] != '0) begin
                if (found)
                    expected_q.push_back(held);
                held = make_result(STAT_DISPATCH, BIN_W'(b), pri, batch_tally[base + b], 1'b0);
                batch_tally[base + b] = '0;
                found = 1'b1;
            end
        end
        if (!found) begin
            expected_q.push_back(make_result(STAT_EMPTY, '0, pri, '0, 1'b1));
        end else begin
            held.last = 1'b1;
            expected_q.push_back(held);
        end
    endtask

    // compare one received word with the oldest expectation
    task automatic check_result(input t_result got);
        t_result want;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected result status=%0d bin=%0d pri=%0d count=%0d last=%0d",
                         $realtime, got.status, got.bin, got.pri, got.count, got.last);
        end else begin
            want = expected_q.pop_front();
            if (want.status !== got.status || want.bin !== got.bin || want.pri !== got.pri ||
                want.count !== got.count || want.last !== got.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("%0t: mismatch expected status=%0d bin=%0d pri=%0d count=%0d last=%0d",
                           $realtime, want.status, want.bin, want.pri, want.count, want.last);
                    $display(", got status=%0d bin=%0d pri=%0d count=%0d last=%0d",
                             got.status, got.bin, got.pri, got.count, got.last);
                end
            end
        end
    endtask

    // watch all three ports at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (batch_tally[k])
                batch_tally[k] = '0;
            pri_en      = 1'b0;
            win_first   = '0;
            win_last    = '0;
            batch_limit = BSIZE_RESET;
            expected_q.delete();
        end else begin
            if (i_out_valid && i_out_ready)
                check_result(make_result(i_status, i_out_bin, i_out_priority, i_out_count,
                                         i_last));
            if (i_in_valid && i_in_ready) begin
                case (i_req_type)
                    REQ_ADD:        predict_add(i_bin_index, i_event_number, i_item_alive);
                    REQ_FLUSH_PRI:  predict_flush(1'b1);
                    REQ_FLUSH_NORM: predict_flush(1'b0);
                    default: ;
                endcase
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[ADDR_W-1:2])
                    REG_PRI_EN:    pri_en      = i_pwdata[0];
                    REG_PRI_FIRST: win_first   = i_pwdata[EVT_W-1:0];
                    REG_PRI_LAST:  win_last    = i_pwdata[EVT_W-1:0];
                    REG_BSIZE:     batch_limit = i_pwdata[CNT_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending        <= expected_q.size();
        o_mismatch_count <= mismatches;
    end

endmodule

// ===== verif/binned_batch_dispatcher_tb.sv =====
`timescale 1ns / 1ps

module binned_batch_dispatcher_tb;
    import bbd_pkg::*;

    // request code the block ignores
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    localparam int RX_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 120;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        req_type;
    logic [ITEM_W-1:0] item_id;
    logic [BIN_W-1:0]  bin_index;
    logic [EVT_W-1:0]  event_number;
    logic              item_alive;
    logic              out_valid;
    logic              out_ready;
    logic [1:0]        status;
    logic [BIN_W-1:0]  out_bin;
    logic              out_priority;
    logic [CNT_W-1:0]  out_count;
    logic              last;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    bit                quiet_mode;
    bit                rx_hold_req;
    int                mismatch_count;
    int                pending_results;

    binned_batch_dispatcher i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_req_type     (req_type),
        .i_item_id      (item_id),
        .i_bin_index    (bin_index),
        .i_event_number (event_number),
        .i_item_alive   (item_alive),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_status       (status),
        .o_out_bin      (out_bin),
        .o_out_priority (out_priority),
        .o_out_count    (out_count),
        .o_last         (last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    binned_batch_dispatcher_checker i_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_req_type       (req_type),
        .i_bin_index      (bin_index),
        .i_event_number   (event_number),
        .i_item_alive     (item_alive),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_status         (status),
        .i_out_bin        (out_bin),
        .i_out_priority   (out_priority),
        .i_out_count      (out_count),
        .i_last           (last),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_pready         (pready),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending_results)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial begin
        #1000000;
        $display("FAILED: results differ");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= quiet_mode || ($urandom_range(0, 99) >= 32);
            end
        end
    end

    // register write: setup then access
    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic en, input logic [EVT_W-1:0] first,
                              input logic [EVT_W-1:0] final_ev, input logic [CNT_W-1:0] bsize);
        write_reg(REG_PRI_EN, DATA_W'(en));
        write_reg(REG_PRI_FIRST, DATA_W'(first));
        write_reg(REG_PRI_LAST, DATA_W'(final_ev));
        write_reg(REG_BSIZE, DATA_W'(bsize));
    endtask

    // offer one request word and hold it until taken
    task automatic send_item(input logic [1:0] req, input logic [ITEM_W-1:0] id,
                             input logic [BIN_W-1:0] bin, input logic [EVT_W-1:0] ev,
                             input logic alive);
        while (!quiet_mode && $urandom_range(0, 99) < 32) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= req;
        item_id      <= id;
        bin_index    <= bin;
        event_number <= ev;
        item_alive   <= alive;
        do @(posedge clk); while (!in_ready);
    endtask

    // stop offering and wait for every expected word
    task automatic drain(input int settle);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
        repeat (settle) @(posedge clk);
    endtask

    // one random request; mostly adds into a few bins so batches fill up
    task automatic random_item(input logic [EVT_W-1:0] first, input logic [EVT_W-1:0] final_ev,
                               output bit counted);
        int               pick;
        logic [1:0]       req;
        logic [BIN_W-1:0] bin;
        logic [EVT_W-1:0] ev;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            req = REQ_UNKNOWN;
        else if (pick < 10)
            req = REQ_FLUSH_PRI;
        else if (pick < 16)
            req = REQ_FLUSH_NORM;
        else
            req = REQ_ADD;
        bin = ($urandom_range(0, 99) < 70) ? BIN_W'($urandom_range(0, 3))
                                           : BIN_W'($urandom_range(0, 63));
        case ($urandom_range(0, 5))
            0: ev = EVT_W'($urandom);
            1: ev = first;
            2: ev = final_ev;
            3: ev = first - 1'b1;
            4: ev = final_ev + 1'b1;
            default: ev = EVT_W'($urandom_range(first, final_ev));
        endcase
        send_item(req, ITEM_W'($urandom), bin, ev, $urandom_range(0, 99) >= 10);
        counted = (req != REQ_UNKNOWN);
    endtask

    task automatic run_phase(input logic en, input logic [EVT_W-1:0] first,
                             input logic [EVT_W-1:0] final_ev, input logic [CNT_W-1:0] bsize,
                             input int n_items);
        int done;
        bit counted;
        set_config(en, first, final_ev, bsize);
        done = 0;
        while (done < n_items) begin
            random_item(first, final_ev, counted);
            if (counted)
                done++;
        end
        drain(SETTLE_CYCLES);
    endtask

    // stimulus and verdict
    initial begin
        quiet_mode   = 1'b0;
        rx_hold_req  = 1'b0;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        req_type     <= REQ_ADD;
        item_id      <= '0;
        bin_index    <= '0;
        event_number <= '0;
        item_alive   <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty flushes, window edges, field extremes, refused and ignored words
        set_config(1'b1, 16'h0100, 16'hFF00, 8'd3);
        send_item(REQ_FLUSH_PRI, '0, '0, '0, 1'b1);
        send_item(REQ_FLUSH_NORM, '0, '0, '0, 1'b1);
        send_item(REQ_ADD, 20'h00000, 6'd0, 16'h0000, 1'b1);
        send_item(REQ_ADD, 20'hFFFFF, 6'd63, 16'hFFFF, 1'b1);
        send_item(REQ_ADD, 20'h00001, 6'd63, 16'h0100, 1'b1);
        send_item(REQ_ADD, 20'h00002, 6'd0, 16'hFF00, 1'b1);
        send_item(REQ_ADD, 20'h00003, 6'd0, 16'h00FF, 1'b1);
        send_item(REQ_ADD, 20'h00004, 6'd0, 16'hFF01, 1'b1);
        send_item(REQ_ADD, 20'h00005, 6'd5, 16'h1000, 1'b0);
        send_item(REQ_UNKNOWN, 20'hABCDE, 6'd21, 16'h5555, 1'b1);
        send_item(REQ_FLUSH_PRI, '0, '0, '0, 1'b1);
        send_item(REQ_FLUSH_NORM, '0, '0, '0, 1'b1);
        drain(SETTLE_CYCLES);

        // window with first above last: nothing is priority
        set_config(1'b1, 16'h8000, 16'h0010, 8'd200);
        for (int k = 0; k < 5; k++)
            send_item(REQ_ADD, ITEM_W'(k), 6'd7, (k < 3) ? 16'h8000 : 16'h0008, 1'b1);
        drain(SETTLE_CYCLES);

        // threshold lowered below a held count
        write_reg(REG_BSIZE, DATA_W'(8'd2));
        send_item(REQ_ADD, 20'h00010, 6'd7, 16'h0009, 1'b1);
        drain(SETTLE_CYCLES);

        // zero batch size dispatches every accepted item; the second word is refused
        write_reg(REG_BSIZE, DATA_W'(8'd0));
        send_item(REQ_ADD, 20'h00011, 6'd9, 16'h0000, 1'b1);
        send_item(REQ_ADD, 20'h00012, 6'd9, 16'h0000, 1'b0);
        drain(SETTLE_CYCLES);

        // random phases; a long result hold-off in the first, no idling in the second
        rx_hold_req = 1'b1;
        run_phase(1'b1, 16'h2000, 16'h9FFF, 8'd4, 45);
        quiet_mode = 1'b1;
        run_phase(1'b0, 16'hFFFF, 16'h0000, 8'd7, 40);
        quiet_mode = 1'b0;
        run_phase(1'b1, 16'h0000, 16'hFFFF, 8'd1, 30);
        run_phase(1'b1, 16'hFFFF, 16'hFFFF, 8'd255, 40);
        run_phase(1'b1, 16'h4000, 16'hC000, 8'd5, 45);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
